[rtl/sule_pkg.sv]
// Shared types and constants for the sorted unique list engine.
package sule_pkg;

	localparam int KEY_W          = 31;
	localparam int CMD_W          = 2;
	localparam int IDX_W          = 6;
	localparam int STATUS_W       = 3;
	localparam int TOTAL_W        = 7;
	localparam int DEF_LIST_DEPTH = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_INSERT = 2'd0,
		CMD_REMOVE = 2'd1,
		CMD_READ   = 2'd2
	} cmd_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED  = 3'd0,
		ST_DUPLICATE = 3'd1,
		ST_FULL      = 3'd2,
		ST_REMOVED   = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_READ_OK   = 3'd5,
		ST_RANGE     = 3'd6,
		ST_ZERO      = 3'd7
	} status_t;

	typedef enum logic [0:0] {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;  // capture the input beat and register the cell compares
		logic exec;  // resolve, update the cell row and load the result register
	} dp_cmd_t;

endpackage

[rtl/sorted_unique_list_engine_top.sv]
// Top level of the sorted unique list engine.
// Keeps up to LIST_DEPTH distinct nonzero 31-bit values in ascending order in a row of
// cells. Every input beat (insert, remove or read) yields exactly one result beat with a
// status, the entry count and a position or read value. In the cycle its beat is taken,
// every cell compares against the key in parallel and the outcome is registered; once
// the result register is free, the datapath resolves the ordered slot, shifts the cell
// row by one place on an insert or remove and loads the result register. The result
// register parts the two sides, so a pending result may wait on out_stall while the
// next beat is taken; the update of that next beat waits only until the result register
// frees. No clearing pass follows reset: cells past the count never reach a result.
module sorted_unique_list_engine_top #(
	parameter int LIST_DEPTH = sule_pkg::DEF_LIST_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [sule_pkg::CMD_W-1:0]    command,
	input  logic [sule_pkg::KEY_W-1:0]    key_value,
	input  logic [sule_pkg::IDX_W-1:0]    read_index,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [sule_pkg::STATUS_W-1:0] status,
	output logic [sule_pkg::TOTAL_W-1:0]  entry_total,
	output logic [sule_pkg::IDX_W-1:0]    position,
	output logic [sule_pkg::KEY_W-1:0]    read_value
);

	sule_pkg::dp_cmd_t dp_cmd;

	sule_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_cmd    (dp_cmd)
	);

	sule_dpath #(
		.LIST_DEPTH (LIST_DEPTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.dp_cmd      (dp_cmd),
		.command     (command),
		.key_value   (key_value),
		.read_index  (read_index),
		.status      (status),
		.entry_total (entry_total),
		.position    (position),
		.read_value  (read_value)
	);

endmodule

[rtl/sule_ctrl.sv]
// Controller state machine: input and output handshakes and datapath sequencing.
module sule_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output sule_pkg::dp_cmd_t dp_cmd
);

	sule_pkg::state_t state_q, state_n;
	logic             out_valid_q, out_valid_n;
	logic             out_free;

	// Hold state and result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sule_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_n;
			out_valid_q <= out_valid_n;
		end
	end

	// Next state and commands
	always_comb begin
		out_free    = !out_valid_q || !out_stall;
		state_n     = state_q;
		out_valid_n = out_valid_q && out_stall;
		dp_cmd      = '0;
		in_stall    = 1'b1;
		unique case (state_q)
			sule_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					dp_cmd.load = 1'b1;
					state_n     = sule_pkg::S_EXEC;
				end
			end
			sule_pkg::S_EXEC: begin
				// wait while the result register still holds an untaken beat
				if (out_free) begin
					dp_cmd.exec = 1'b1;
					out_valid_n = 1'b1;
					state_n     = sule_pkg::S_IDLE;
				end
			end
			default: begin
				state_n = sule_pkg::S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

[rtl/sule_dpath.sv]
// Datapath: row of sorted cells with parallel compares, shift update and result register.
module sule_dpath #(
	parameter int LIST_DEPTH = sule_pkg::DEF_LIST_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sule_pkg::dp_cmd_t             dp_cmd,
	input  logic [sule_pkg::CMD_W-1:0]    command,
	input  logic [sule_pkg::KEY_W-1:0]    key_value,
	input  logic [sule_pkg::IDX_W-1:0]    read_index,
	output logic [sule_pkg::STATUS_W-1:0] status,
	output logic [sule_pkg::TOTAL_W-1:0]  entry_total,
	output logic [sule_pkg::IDX_W-1:0]    position,
	output logic [sule_pkg::KEY_W-1:0]    read_value
);

	localparam int CNT_W = $clog2(LIST_DEPTH + 1);

	// cell row and fill count
	logic [sule_pkg::KEY_W-1:0] entries_q [LIST_DEPTH];
	logic [CNT_W-1:0]           count_q, count_n;

	// captured beat and registered compares
	logic [sule_pkg::CMD_W-1:0] cmd_q;
	logic [sule_pkg::KEY_W-1:0] key_q;
	logic [sule_pkg::IDX_W-1:0] idx_q;
	logic [LIST_DEPTH-1:0]      lt_q;
	logic [LIST_DEPTH-1:0]      eq_q;
	logic [LIST_DEPTH-1:0]      sel_q;
	logic [LIST_DEPTH-1:0]      lt_n, eq_n, sel_n;

	// result register
	logic [sule_pkg::STATUS_W-1:0] status_q, status_n;
	logic [sule_pkg::TOTAL_W-1:0]  total_q;
	logic [sule_pkg::IDX_W-1:0]    pos_q, pos_n;
	logic [sule_pkg::KEY_W-1:0]    rval_q, rval_n;

	// execute-side decode
	logic [CNT_W-1:0]           at;
	logic                       found;
	logic                       is_full;
	logic                       rd_ok;
	logic [sule_pkg::KEY_W-1:0] rd_data;
	logic                       do_ins, do_rem;
	logic [sule_pkg::KEY_W-1:0] ins_e [LIST_DEPTH];
	logic [sule_pkg::KEY_W-1:0] rem_e [LIST_DEPTH];

	// Compare the incoming key against every valid cell at once
	always_comb begin
		for (int i = 0; i < LIST_DEPTH; i++) begin
			lt_n[i]  = (CNT_W'(i) < count_q) && (entries_q[i] < key_value);
			eq_n[i]  = (CNT_W'(i) < count_q) && (entries_q[i] == key_value);
			sel_n[i] = (32'(read_index) == i);
		end
	end

	// Capture the beat with its compare vectors
	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			cmd_q <= command;
			key_q <= key_value;
			idx_q <= read_index;
			lt_q  <= lt_n;
			eq_q  <= eq_n;
			sel_q <= sel_n;
		end
	end

	// Resolve the ordered position, read data and new cell contents
	always_comb begin
		// lt_q is a run of ones from cell 0; the first zero marks the slot
		at = CNT_W'(LIST_DEPTH);
		if (!lt_q[0]) begin
			at = '0;
		end
		for (int i = 1; i < LIST_DEPTH; i++) begin
			if (lt_q[i-1] && !lt_q[i]) begin
				at = CNT_W'(i);
			end
		end
		found   = |eq_q;
		is_full = (count_q == CNT_W'(LIST_DEPTH));
		rd_ok   = (32'(idx_q) < 32'(count_q));
		rd_data = '0;
		for (int i = 0; i < LIST_DEPTH; i++) begin
			if (sel_q[i]) begin
				rd_data = rd_data | entries_q[i];
			end
		end

		// insert: cells at or above the slot take the lower neighbor, the slot takes the key
		ins_e[0] = key_q;
		for (int i = 1; i < LIST_DEPTH; i++) begin
			ins_e[i] = lt_q[i-1] ? key_q : entries_q[i-1];
		end
		// remove: cells at or above the match take the upper neighbor
		for (int i = 0; i < LIST_DEPTH - 1; i++) begin
			rem_e[i] = entries_q[i+1];
		end
		rem_e[LIST_DEPTH-1] = entries_q[LIST_DEPTH-1];

		do_ins   = 1'b0;
		do_rem   = 1'b0;
		count_n  = count_q;
		status_n = sule_pkg::ST_ZERO;
		pos_n    = '0;
		rval_n   = '0;
		if (cmd_q[1]) begin
			// command code three reads as well
			pos_n = idx_q;
			if (rd_ok) begin
				status_n = sule_pkg::ST_READ_OK;
				rval_n   = rd_data;
			end else begin
				status_n = sule_pkg::ST_RANGE;
			end
		end else if (key_q == '0) begin
			status_n = sule_pkg::ST_ZERO;
		end else if (cmd_q == sule_pkg::CMD_INSERT) begin
			if (found) begin
				status_n = sule_pkg::ST_DUPLICATE;
				pos_n    = sule_pkg::IDX_W'(at);
			end else if (is_full) begin
				status_n = sule_pkg::ST_FULL;
			end else begin
				do_ins   = 1'b1;
				count_n  = count_q + CNT_W'(1);
				status_n = sule_pkg::ST_INSERTED;
				pos_n    = sule_pkg::IDX_W'(at);
			end
		end else begin
			if (found) begin
				do_rem   = 1'b1;
				count_n  = count_q - CNT_W'(1);
				status_n = sule_pkg::ST_REMOVED;
				pos_n    = sule_pkg::IDX_W'(at);
			end else begin
				status_n = sule_pkg::ST_NOT_FOUND;
			end
		end
	end

	// Advance the cell row
	always_ff @(posedge clk) begin
		if (dp_cmd.exec) begin
			for (int i = 0; i < LIST_DEPTH; i++) begin
				if (!lt_q[i]) begin
					if (do_ins) begin
						entries_q[i] <= ins_e[i];
					end else if (do_rem) begin
						entries_q[i] <= rem_e[i];
					end
				end
			end
		end
	end

	// Hold the fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (dp_cmd.exec) begin
			count_q <= count_n;
		end
	end

	// Load the result beat
	always_ff @(posedge clk) begin
		if (dp_cmd.exec) begin
			status_q <= status_n;
			total_q  <= sule_pkg::TOTAL_W'(count_n);
			pos_q    <= pos_n;
			rval_q   <= rval_n;
		end
	end

	assign status      = status_q;
	assign entry_total = total_q;
	assign position    = pos_q;
	assign read_value  = rval_q;

endmodule

[tb/sv/sorted_unique_list_engine_top_tb.sv]
// Self-checking testbench for the sorted unique list engine: directed and random list traffic.
`timescale 1ns / 100ps

module sorted_unique_list_engine_top_tb;
	import sule_pkg::*;

	localparam int LIST_DEPTH = DEF_LIST_DEPTH;
	localparam int N_ITEMS = 1700;
	localparam int MAX_REPORTS = 10;
	// Command 3 is not named in the package; only bit 1 is decoded, so it reads.
	localparam logic [CMD_W-1:0] CMD_READ_ALT = 2'd3;
	localparam int FILL_PHASE = 0;
	localparam int DRAIN_PHASE = 2;

	typedef struct packed {
		status_t              st;
		logic [TOTAL_W-1:0]   total;
		logic [IDX_W-1:0]     pos;
		logic [KEY_W-1:0]     rval;
	} list_result_t;

	// Shadow list and queue of results still owed by the block.
	class list_scoreboard;
		logic [KEY_W-1:0] entries [LIST_DEPTH];
		int unsigned count;
		list_result_t expected_results[$];
		int unsigned errors;

		function new();
			count = 0;
			errors = 0;
		endfunction

		// First slot whose entry is not below the key.
		function int unsigned find_slot(logic [KEY_W-1:0] key);
			int unsigned i;
			for (i = 0; i < count; i++) begin
				if (entries[i] >= key) begin
					return i;
				end
			end
			return count;
		endfunction

		function void note_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key,
				logic [IDX_W-1:0] idx);
			list_result_t r;
			int unsigned at;
			int unsigned i;
			bit hit;
			r.pos = '0;
			r.rval = '0;
			// read wins over the key checks; command 3 also lands here
			if (cmd[1]) begin
				r.pos = idx;
				if (idx < count) begin
					r.st = ST_READ_OK;
					r.rval = entries[idx];
				end else begin
					r.st = ST_RANGE;
				end
			end else if (key == '0) begin
				r.st = ST_ZERO;
			end else begin
				at = find_slot(key);
				hit = (at < count) && (entries[at] == key);
				if (cmd == CMD_INSERT) begin
					// duplicate check comes before the full check
					if (hit) begin
						r.st = ST_DUPLICATE;
						r.pos = at[IDX_W-1:0];
					end else if (count >= LIST_DEPTH) begin
						r.st = ST_FULL;
					end else begin
						for (i = count; i > at; i--) begin
							entries[i] = entries[i-1];
						end
						entries[at] = key;
						count++;
						r.st = ST_INSERTED;
						r.pos = at[IDX_W-1:0];
					end
				end else begin
					if (hit) begin
						for (i = at; i + 1 < count; i++) begin
							entries[i] = entries[i+1];
						end
						count--;
						r.st = ST_REMOVED;
						r.pos = at[IDX_W-1:0];
					end else begin
						r.st = ST_NOT_FOUND;
					end
				end
			end
			r.total = count[TOTAL_W-1:0];
			expected_results.push_back(r);
		endfunction

		function void check_result(logic [STATUS_W-1:0] st, logic [TOTAL_W-1:0] total,
				logic [IDX_W-1:0] pos, logic [KEY_W-1:0] rval);
			list_result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("ERROR %0t: unexpected result status=%0d total=%0d pos=%0d val=%0d",
						$realtime, st, total, pos, rval);
				end
				return;
			end
			want = expected_results.pop_front();
			if (st !== want.st || total !== want.total || pos !== want.pos ||
					rval !== want.rval) begin
				errors++;
				if (errors <= MAX_REPORTS) begin
					$display("ERROR %0t: status exp %0d got %0d, total exp %0d got %0d",
						$realtime, want.st, st, want.total, total);
					$display("      position exp %0d got %0d, read_value exp %0d got %0d",
						want.pos, pos, want.rval, rval);
				end
			end
		endfunction

		function int unsigned pending();
			return expected_results.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [CMD_W-1:0]   command = '0;
	logic [KEY_W-1:0]   key_value = '0;
	logic [IDX_W-1:0]   read_index = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [TOTAL_W-1:0] entry_total;
	logic [IDX_W-1:0]   position;
	logic [KEY_W-1:0]   read_value;

	list_scoreboard sb = new();
	bit steady = 1'b0;

	sorted_unique_list_engine_top #(
		.LIST_DEPTH(LIST_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.key_value(key_value),
		.read_index(read_index),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.entry_total(entry_total),
		.position(position),
		.read_value(read_value)
	);

	always #2 clk = ~clk;

	// Present one beat after an optional idle gap; record it once taken.
	task automatic drive_beat(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
			input logic [IDX_W-1:0] idx);
		int unsigned gap;
		gap = 0;
		if (!steady && $urandom_range(99) < 9) begin
			gap = $urandom_range(3, 1);
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		key_value <= key;
		read_index <= idx;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_command(cmd, key, idx);
	endtask

	// Mostly stored or small keys so duplicates and hits are common.
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned roll;
		logic [KEY_W-1:0] k;
		roll = $urandom_range(99);
		if (roll < 5) begin
			k = '0;
		end else if (roll < 45 && sb.count > 0) begin
			k = sb.entries[$urandom_range(sb.count - 1)];
		end else if (roll < 80) begin
			k = KEY_W'($urandom_range(120, 1));
		end else begin
			k = KEY_W'($urandom());
		end
		return k;
	endfunction

	// Reads mostly land inside the list, the rest anywhere in the index range.
	function automatic logic [IDX_W-1:0] pick_index();
		logic [IDX_W-1:0] ix;
		if (sb.count > 0 && $urandom_range(99) < 70) begin
			ix = IDX_W'($urandom_range(sb.count - 1));
		end else begin
			ix = IDX_W'($urandom_range(63));
		end
		return ix;
	endfunction

	// Random traffic in repeating fill, mixed and drain phases.
	task automatic run_random(input int unsigned n_items);
		int unsigned done;
		int unsigned phase;
		int unsigned step;
		int unsigned ins_pct;
		int unsigned rem_pct;
		int unsigned roll;
		logic [CMD_W-1:0] cmd;
		done = 0;
		phase = 0;
		while (done < n_items) begin
			case (phase % 3)
				FILL_PHASE: begin
					ins_pct = 75;
					rem_pct = 10;
				end
				DRAIN_PHASE: begin
					ins_pct = 10;
					rem_pct = 75;
				end
				default: begin
					ins_pct = 35;
					rem_pct = 35;
				end
			endcase
			for (step = 0; step < 240 && done < n_items; step++) begin
				steady = (done >= 700 && done < 1000);
				roll = $urandom_range(99);
				if (roll < ins_pct) begin
					cmd = CMD_INSERT;
				end else if (roll < ins_pct + rem_pct) begin
					cmd = CMD_REMOVE;
				end else if ($urandom_range(99) < 15) begin
					cmd = CMD_READ_ALT;
				end else begin
					cmd = CMD_READ;
				end
				drive_beat(cmd, pick_key(), pick_index());
				done++;
			end
			phase++;
		end
		steady = 1'b0;
	endtask

	// Result side: check taken beats, stall at random outside the steady stretch.
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				sb.check_result(status, entry_total, position, read_value);
			end
			out_stall <= !steady && ($urandom_range(99) < 9);
		end
	end

	// Stimulus and end of run.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corners, zero keys
		drive_beat(CMD_READ, '0, '0);
		drive_beat(CMD_INSERT, '0, '0);
		drive_beat(CMD_REMOVE, '0, 6'd63);
		drive_beat(CMD_REMOVE, 31'd5, '0);
		// insert at end, at front, in the middle, duplicate
		drive_beat(CMD_INSERT, 31'h7FFF_FFFF, '0);
		drive_beat(CMD_INSERT, 31'd1, '0);
		drive_beat(CMD_INSERT, 31'd1000, '0);
		drive_beat(CMD_INSERT, 31'd1000, 6'd63);
		drive_beat(CMD_INSERT, 31'h4000_0000, '0);
		drive_beat(CMD_INSERT, 31'h2AAA_AAAA, '0);
		drive_beat(CMD_INSERT, 31'h5555_5555, '0);
		// reads in range, past the count and at the top index; read ignores the key
		drive_beat(CMD_READ, 31'h7FFF_FFFF, 6'd0);
		drive_beat(CMD_READ, '0, 6'd5);
		drive_beat(CMD_READ, '0, 6'd6);
		drive_beat(CMD_READ, '0, 6'd63);
		drive_beat(CMD_READ_ALT, 31'd1000, 6'd2);
		drive_beat(CMD_READ_ALT, '0, 6'd42);
		// remove from middle, front and end, then two misses
		drive_beat(CMD_REMOVE, 31'd1000, '0);
		drive_beat(CMD_REMOVE, 31'd1, '0);
		drive_beat(CMD_REMOVE, 31'h7FFF_FFFF, '0);
		drive_beat(CMD_REMOVE, 31'd1000, '0);
		drive_beat(CMD_REMOVE, 31'h7FFF_FFFE, '0);

		run_random(N_ITEMS);
		in_valid <= 1'b0;

		// drain outstanding results, then watch for strays
		while (sb.pending() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Hang guard.
	initial begin
		#400000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
